// ----- rtl/dfhsm_pkg.sv -----
// Shared types and constants for the dryer fan and heater safety monitor.
// No dependencies; the other files that use this package refer to it by scoped names.
`timescale 1ns / 1ps

package dfhsm_pkg;

    // Sticky fault codes as seen on the result channel.
    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_FAN_STALL   = 2'd1,
        ERR_OVERHEAT    = 2'd2,
        ERR_SENSOR_LOST = 2'd3
    } t_err_code;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FAN_MIN_RPM       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_GRACE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_GRACE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_SPEED_PERCENT = 3'd4;

    // Register reset values.
    localparam logic [15:0]        RST_FAN_MIN_RPM       = 16'd600;
    localparam logic signed [7:0]  RST_OVERHEAT_LIMIT    = 8'sd40;
    localparam logic [5:0]         RST_FAN_GRACE         = 6'd20;
    localparam logic [5:0]         RST_SENSOR_GRACE      = 6'd50;
    localparam logic [6:0]         RST_FAN_SPEED_PERCENT = 7'd40;

    // Arithmetic constants.
    localparam logic [15:0] PULSE_MAX     = 16'hFFFF;
    localparam logic [20:0] RPM_PER_PULSE = 21'd30;
    localparam logic [6:0]  PCT_MIN       = 7'd20;
    localparam logic [6:0]  PCT_MAX       = 7'd100;
    localparam logic [11:0] FAN_CMP_STEP  = 12'd36;
    localparam logic [11:0] FAN_CMP_SAFE  = 12'd3600;
    localparam logic [7:0]  REQ_MAX       = 8'd100;
    localparam logic [9:0]  HEAT_STEP     = 10'd10;
    localparam logic [9:0]  HEAT_FULL     = 10'd1000;

    typedef struct packed {
        logic [15:0]       fan_min_rpm;
        logic signed [7:0] overheat_limit;
        logic [5:0]        fan_grace;
        logic [5:0]        sensor_grace;
        logic [6:0]        fan_speed_percent;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        tach_pulses;
        logic [9:0]        elapsed_ms;
        logic signed [7:0] temperature;
        logic [7:0]        heater_request;
    } t_item;

    typedef struct packed {
        logic [20:0] fan_rpm;
        t_err_code   error_code;
        logic [11:0] fan_compare;
        logic [9:0]  heater_compare;
    } t_result;

endpackage

// ----- rtl/dfhsm_in_if.sv -----
// Tick input channel of the safety monitor: valid/ready handshake and payload.
// No dependencies.
`timescale 1ns / 1ps

interface dfhsm_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        tach_pulses;
    logic [9:0]        elapsed_ms;
    logic signed [7:0] temperature;
    logic [7:0]        heater_request;

    modport source (
        output valid, tach_pulses, elapsed_ms, temperature, heater_request,
        input  ready
    );
    modport sink (
        input  valid, tach_pulses, elapsed_ms, temperature, heater_request,
        output ready
    );
endinterface

// ----- rtl/dfhsm_out_if.sv -----
// Result channel of the safety monitor: valid/ready handshake and payload.
// No dependencies.
`timescale 1ns / 1ps

interface dfhsm_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] fan_rpm;
    logic [1:0]  error_code;
    logic [11:0] fan_compare;
    logic [9:0]  heater_compare;

    modport source (
        output valid, fan_rpm, error_code, fan_compare, heater_compare,
        input  ready
    );
    modport sink (
        input  valid, fan_rpm, error_code, fan_compare, heater_compare,
        output ready
    );
endinterface

// ----- rtl/dfhsm_cfg.sv -----
// Configuration register bank of the safety monitor.
// Depends on dfhsm_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module dfhsm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dfhsm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfhsm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output dfhsm_pkg::t_cfg                o_cfg
);

    dfhsm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fan_min_rpm       <= dfhsm_pkg::RST_FAN_MIN_RPM;
            r_cfg.overheat_limit    <= dfhsm_pkg::RST_OVERHEAT_LIMIT;
            r_cfg.fan_grace         <= dfhsm_pkg::RST_FAN_GRACE;
            r_cfg.sensor_grace      <= dfhsm_pkg::RST_SENSOR_GRACE;
            r_cfg.fan_speed_percent <= dfhsm_pkg::RST_FAN_SPEED_PERCENT;
        end else if (i_cfg_we) begin
            // Writes to an index beyond the bank are dropped.
            unique case (i_cfg_idx)
                dfhsm_pkg::CFG_FAN_MIN_RPM: begin
                    r_cfg.fan_min_rpm <= i_cfg_wdata;
                end
                dfhsm_pkg::CFG_OVERHEAT_LIMIT: begin
                    r_cfg.overheat_limit <= $signed(i_cfg_wdata[7:0]);
                end
                dfhsm_pkg::CFG_FAN_GRACE: begin
                    r_cfg.fan_grace <= i_cfg_wdata[5:0];
                end
                dfhsm_pkg::CFG_SENSOR_GRACE: begin
                    r_cfg.sensor_grace <= i_cfg_wdata[5:0];
                end
                dfhsm_pkg::CFG_FAN_SPEED_PERCENT: begin
                    r_cfg.fan_speed_percent <= i_cfg_wdata[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/dfhsm_core.sv -----
// Per-tick supervisor logic: tach window, fault checks and PWM compares.
// Holds the monitor state; depends on dfhsm_pkg for types and constants.
`timescale 1ns / 1ps

module dfhsm_core #(
    parameter int WINDOW_MS = 1000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  dfhsm_pkg::t_item   i_item,
    input  dfhsm_pkg::t_cfg    i_cfg,
    output dfhsm_pkg::t_result o_result
);

    localparam logic [10:0] WindowLimit = 11'(WINDOW_MS);

    logic [15:0]          r_pulse_accum, n_pulse_accum;
    logic [10:0]          r_window_ms, n_window_ms;
    logic [20:0]          r_rpm_held, n_rpm_held;
    logic [5:0]           r_fan_low_count, n_fan_low_count;
    logic [5:0]           r_sensor_low_count, n_sensor_low_count;
    dfhsm_pkg::t_err_code r_fault_code, n_fault_code;

    logic [16:0] pulse_sum;
    logic [15:0] pulse_sat;
    logic [10:0] window_sum;
    logic [6:0]  pct_clamped;
    logic [6:0]  req_clamped;

    always_comb begin
        pulse_sum  = {1'b0, r_pulse_accum} + 17'(i_item.tach_pulses);
        pulse_sat  = pulse_sum[16] ? dfhsm_pkg::PULSE_MAX : pulse_sum[15:0];
        window_sum = r_window_ms + 11'(i_item.elapsed_ms);

        // The tick's own pulses count toward the window it closes.
        if (window_sum >= WindowLimit) begin
            n_rpm_held    = 21'(pulse_sat) * dfhsm_pkg::RPM_PER_PULSE;
            n_pulse_accum = '0;
            n_window_ms   = '0;
        end else begin
            n_rpm_held    = r_rpm_held;
            n_pulse_accum = pulse_sat;
            n_window_ms   = window_sum;
        end

        n_fault_code = r_fault_code;

        if (n_rpm_held < 21'(i_cfg.fan_min_rpm)) begin
            if (r_fan_low_count < i_cfg.fan_grace) begin
                n_fan_low_count = r_fan_low_count + 6'd1;
            end else begin
                n_fan_low_count = r_fan_low_count;
                n_fault_code    = dfhsm_pkg::ERR_FAN_STALL;
            end
        end else begin
            n_fan_low_count = '0;
        end

        if (i_item.temperature > i_cfg.overheat_limit) begin
            n_fault_code = dfhsm_pkg::ERR_OVERHEAT;
        end

        if (i_item.temperature <= 8'sd0) begin
            if (r_sensor_low_count < i_cfg.sensor_grace) begin
                n_sensor_low_count = r_sensor_low_count + 6'd1;
            end else begin
                n_sensor_low_count = r_sensor_low_count;
                n_fault_code       = dfhsm_pkg::ERR_SENSOR_LOST;
            end
        end else begin
            n_sensor_low_count = '0;
        end

        if (i_cfg.fan_speed_percent > dfhsm_pkg::PCT_MAX) begin
            pct_clamped = dfhsm_pkg::PCT_MAX;
        end else if (i_cfg.fan_speed_percent < dfhsm_pkg::PCT_MIN) begin
            pct_clamped = dfhsm_pkg::PCT_MIN;
        end else begin
            pct_clamped = i_cfg.fan_speed_percent;
        end

        if (i_item.heater_request > dfhsm_pkg::REQ_MAX) begin
            req_clamped = dfhsm_pkg::REQ_MAX[6:0];
        end else begin
            req_clamped = i_item.heater_request[6:0];
        end

        o_result.fan_rpm    = n_rpm_held;
        o_result.error_code = n_fault_code;
        // Any latched fault forces full fan and the heater off.
        if (n_fault_code != dfhsm_pkg::ERR_NONE) begin
            o_result.fan_compare    = dfhsm_pkg::FAN_CMP_SAFE;
            o_result.heater_compare = dfhsm_pkg::HEAT_FULL;
        end else begin
            o_result.fan_compare    = 12'(pct_clamped) * dfhsm_pkg::FAN_CMP_STEP;
            o_result.heater_compare = dfhsm_pkg::HEAT_FULL
                                    - 10'(req_clamped) * dfhsm_pkg::HEAT_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_accum      <= '0;
            r_window_ms        <= '0;
            r_rpm_held         <= '0;
            r_fan_low_count    <= '0;
            r_sensor_low_count <= '0;
            r_fault_code       <= dfhsm_pkg::ERR_NONE;
        end else if (i_advance) begin
            r_pulse_accum      <= n_pulse_accum;
            r_window_ms        <= n_window_ms;
            r_rpm_held         <= n_rpm_held;
            r_fan_low_count    <= n_fan_low_count;
            r_sensor_low_count <= n_sensor_low_count;
            r_fault_code       <= n_fault_code;
        end
    end

endmodule

// ----- rtl/dryer_fan_heater_safety_monitor.sv -----
// Top level of the dryer fan and heater safety monitor.
// Depends on dfhsm_pkg, dfhsm_in_if, dfhsm_out_if, dfhsm_cfg and dfhsm_core.
`timescale 1ns / 1ps

// Usage:
// Each beat on i_item is one supervisor tick: tach pulses and milliseconds
// since the previous tick, the temperature and the heater request. Every
// accepted tick yields exactly one beat on o_result with the held fan speed,
// the sticky error code and the fan and heater PWM compare values.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata while no
// tick is in flight; index 0..4 selects the register, other indexes are
// ignored.
// A tick is captured in an input register, evaluated against the monitor
// state by one level of compare and small-multiply logic, and lands in the
// result register, which drives o_result.valid.
// One tick per cycle is sustained while o_result.ready stays high; the rate
// is set by the single state update per tick between the two registers.
// When the receiver holds o_result.ready low, the result register holds its
// beat and the input register can still take one more tick before
// i_item.ready drops. Reset clears the valid flags of both registers, the
// accumulators, the counters, the error code, and loads the register defaults.
module dryer_fan_heater_safety_monitor #(
    parameter int WINDOW_MS = 1000
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dfhsm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dfhsm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    dfhsm_in_if.sink                         i_item,
    dfhsm_out_if.source                      o_result
);

    dfhsm_pkg::t_cfg    cfg;
    dfhsm_pkg::t_item   r_in;
    logic               r_in_valid;
    dfhsm_pkg::t_result r_out;
    logic               r_out_valid;
    dfhsm_pkg::t_result core_result;
    logic               advance;
    logic               in_take;

    dfhsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dfhsm_core #(
        .WINDOW_MS (WINDOW_MS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    // The captured tick moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_take      = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.tach_pulses    <= i_item.tach_pulses;
            r_in.elapsed_ms     <= i_item.elapsed_ms;
            r_in.temperature    <= i_item.temperature;
            r_in.heater_request <= i_item.heater_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.fan_rpm        = r_out.fan_rpm;
    assign o_result.error_code     = r_out.error_code;
    assign o_result.fan_compare    = r_out.fan_compare;
    assign o_result.heater_compare = r_out.heater_compare;

    // A latched fault always comes with the safe drive values.
    a_safe_drive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != dfhsm_pkg::ERR_NONE) |->
        (r_out.fan_compare == dfhsm_pkg::FAN_CMP_SAFE &&
         r_out.heater_compare == dfhsm_pkg::HEAT_FULL))
        else $error("fault result without safe drive values");

    // Once a fault has been reported, the next result still carries one.
    a_fault_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != dfhsm_pkg::ERR_NONE && advance) |=>
        (r_out.error_code != dfhsm_pkg::ERR_NONE))
        else $error("fault code cleared without reset");

    // Input back-pressure only arises from a full pipe behind a stalled sink.
    a_ready_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_in_valid && r_out_valid && !o_result.ready))
        else $error("input stalled while the pipe can move");

    // Normal fan compare stays within the clamped percent range.
    a_fan_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.fan_compare >= 12'd720 &&
                         r_out.fan_compare <= dfhsm_pkg::FAN_CMP_SAFE))
        else $error("fan compare out of range");

endmodule

// ----- verif/tb_dryer_fan_heater_safety_monitor.sv -----
// Self-checking testbench for the dryer fan and heater safety monitor.
// Depends on dfhsm_pkg, dfhsm_in_if, dfhsm_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_dryer_fan_heater_safety_monitor;

    localparam int WIN_LEN_MS = 1000;
    localparam logic [dfhsm_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST =
        dfhsm_pkg::CFG_FAN_SPEED_PERCENT;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [dfhsm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [dfhsm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    dfhsm_in_if  tick_if ();
    dfhsm_out_if rslt_if ();

    dryer_fan_heater_safety_monitor #(
        .WINDOW_MS (WIN_LEN_MS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (tick_if),
        .o_result    (rslt_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor model state and its copy of the registers.
    dfhsm_pkg::t_cfg      shadow_cfg;
    logic [15:0]          m_pulse_acc;
    logic [10:0]          m_win_ms;
    logic [20:0]          m_rpm_hold;
    logic [5:0]           m_fan_low_cnt;
    logic [5:0]           m_sens_low_cnt;
    dfhsm_pkg::t_err_code m_fault;

    dfhsm_pkg::t_result monitor_status_q[$];
    int                 mismatch_cnt = 0;

    // Stimulus control shared between the test tasks and the sink process.
    dfhsm_pkg::t_cfg cur_cfg;
    bit   idle_on     = 1'b1;
    bit   src_idle_en = 1'b1;
    bit   snk_idle_en = 1'b1;
    bit   safe_mode   = 1'b0;
    int   neg_run     = 0;
    int   hold_off_cycles = 0;

    function automatic dfhsm_pkg::t_result tick_monitor_step(dfhsm_pkg::t_item it);
        dfhsm_pkg::t_result r;
        logic [16:0]        acc_sum;
        logic [6:0]         pct;
        logic [7:0]         req;
        acc_sum = {1'b0, m_pulse_acc} + {9'd0, it.tach_pulses};
        m_pulse_acc = acc_sum[16] ? dfhsm_pkg::PULSE_MAX : acc_sum[15:0];
        m_win_ms = m_win_ms + {1'b0, it.elapsed_ms};
        // This tick's pulses and time count before the window test.
        if (m_win_ms >= WIN_LEN_MS) begin
            m_rpm_hold  = 21'(m_pulse_acc) * dfhsm_pkg::RPM_PER_PULSE;
            m_pulse_acc = '0;
            m_win_ms    = '0;
        end
        if (m_rpm_hold < {5'd0, shadow_cfg.fan_min_rpm}) begin
            if (m_fan_low_cnt < shadow_cfg.fan_grace) begin
                m_fan_low_cnt = m_fan_low_cnt + 6'd1;
            end else begin
                m_fault = dfhsm_pkg::ERR_FAN_STALL;
            end
        end else begin
            m_fan_low_cnt = '0;
        end
        if ($signed(it.temperature) > $signed(shadow_cfg.overheat_limit)) begin
            m_fault = dfhsm_pkg::ERR_OVERHEAT;
        end
        if ($signed(it.temperature) <= 8'sd0) begin
            if (m_sens_low_cnt < shadow_cfg.sensor_grace) begin
                m_sens_low_cnt = m_sens_low_cnt + 6'd1;
            end else begin
                m_fault = dfhsm_pkg::ERR_SENSOR_LOST;
            end
        end else begin
            m_sens_low_cnt = '0;
        end
        r.fan_rpm    = m_rpm_hold;
        r.error_code = m_fault;
        if (m_fault != dfhsm_pkg::ERR_NONE) begin
            r.fan_compare    = dfhsm_pkg::FAN_CMP_SAFE;
            r.heater_compare = dfhsm_pkg::HEAT_FULL;
        end else begin
            pct = shadow_cfg.fan_speed_percent;
            if (pct > dfhsm_pkg::PCT_MAX) pct = dfhsm_pkg::PCT_MAX;
            if (pct < dfhsm_pkg::PCT_MIN) pct = dfhsm_pkg::PCT_MIN;
            req = (it.heater_request > dfhsm_pkg::REQ_MAX) ? dfhsm_pkg::REQ_MAX
                                                           : it.heater_request;
            r.fan_compare    = 12'(pct) * dfhsm_pkg::FAN_CMP_STEP;
            r.heater_compare = dfhsm_pkg::HEAT_FULL - dfhsm_pkg::HEAT_STEP * 10'(req);
        end
        return r;
    endfunction

    // Register writes, accepted ticks and result beats, all seen at the clock edge.
    always @(posedge clk) begin : status_check
        dfhsm_pkg::t_item   seen;
        dfhsm_pkg::t_result want;
        dfhsm_pkg::t_result got;
        if (!rst_n) begin
            shadow_cfg.fan_min_rpm       <= dfhsm_pkg::RST_FAN_MIN_RPM;
            shadow_cfg.overheat_limit    <= dfhsm_pkg::RST_OVERHEAT_LIMIT;
            shadow_cfg.fan_grace         <= dfhsm_pkg::RST_FAN_GRACE;
            shadow_cfg.sensor_grace      <= dfhsm_pkg::RST_SENSOR_GRACE;
            shadow_cfg.fan_speed_percent <= dfhsm_pkg::RST_FAN_SPEED_PERCENT;
            m_pulse_acc    = '0;
            m_win_ms       = '0;
            m_rpm_hold     = '0;
            m_fan_low_cnt  = '0;
            m_sens_low_cnt = '0;
            m_fault        = dfhsm_pkg::ERR_NONE;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    dfhsm_pkg::CFG_FAN_MIN_RPM:
                        shadow_cfg.fan_min_rpm <= cfg_wdata;
                    dfhsm_pkg::CFG_OVERHEAT_LIMIT:
                        shadow_cfg.overheat_limit <= cfg_wdata[7:0];
                    dfhsm_pkg::CFG_FAN_GRACE:
                        shadow_cfg.fan_grace <= cfg_wdata[5:0];
                    dfhsm_pkg::CFG_SENSOR_GRACE:
                        shadow_cfg.sensor_grace <= cfg_wdata[5:0];
                    dfhsm_pkg::CFG_FAN_SPEED_PERCENT:
                        shadow_cfg.fan_speed_percent <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (tick_if.valid && tick_if.ready) begin
                seen.tach_pulses    = tick_if.tach_pulses;
                seen.elapsed_ms     = tick_if.elapsed_ms;
                seen.temperature    = tick_if.temperature;
                seen.heater_request = tick_if.heater_request;
                monitor_status_q.push_back(tick_monitor_step(seen));
            end
            if (rslt_if.valid && rslt_if.ready) begin
                if (monitor_status_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: status beat with no tick pending", $time);
                    end
                end else begin
                    want = monitor_status_q.pop_front();
                    got.fan_rpm        = rslt_if.fan_rpm;
                    got.error_code     = dfhsm_pkg::t_err_code'(rslt_if.error_code);
                    got.fan_compare    = rslt_if.fan_compare;
                    got.heater_compare = rslt_if.heater_compare;
                    if (got.fan_rpm !== want.fan_rpm || got.error_code !== want.error_code ||
                        got.fan_compare !== want.fan_compare ||
                        got.heater_compare !== want.heater_compare) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: exp rpm %0d err %0d fan %0d heat %0d", $time,
                                     want.fan_rpm, want.error_code, want.fan_compare,
                                     want.heater_compare);
                            $display("%0t: got rpm %0d err %0d fan %0d heat %0d", $time,
                                     got.fan_rpm, got.error_code, got.fan_compare,
                                     got.heater_compare);
                        end
                    end
                end
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        rslt_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_cycles != 0) begin
                rslt_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 11);
                rslt_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                rslt_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic dfhsm_pkg::t_item mk_tick(int pulses, int ms, int temp, int req);
        dfhsm_pkg::t_item it;
        it.tach_pulses    = 8'(pulses);
        it.elapsed_ms     = 10'(ms);
        it.temperature    = 8'(temp);
        it.heater_request = 8'(req);
        return it;
    endfunction

    function automatic int rand_temp();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3) return $urandom_range(0, 40) - 40;
        if (roll == 3) return $urandom_range(0, 255);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [5:0] grace_pick();
        case ($urandom_range(0, 3))
            0:       return 6'd0;
            1:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    // Settings that never trip the fan or overheat check, so the normal compare path shows.
    function automatic dfhsm_pkg::t_cfg safe_cfg();
        dfhsm_pkg::t_cfg c;
        c.fan_min_rpm       = 16'd0;
        c.overheat_limit    = 8'sd127;
        c.fan_grace         = grace_pick();
        c.sensor_grace      = grace_pick();
        c.fan_speed_percent = 7'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic dfhsm_pkg::t_cfg fault_cfg();
        dfhsm_pkg::t_cfg c;
        case ($urandom_range(0, 3))
            0:       c.fan_min_rpm = 16'd0;
            1:       c.fan_min_rpm = 16'hFFFF;
            default: c.fan_min_rpm = 16'($urandom_range(0, 40000));
        endcase
        case ($urandom_range(0, 3))
            0:       c.overheat_limit = -8'sd40;
            1:       c.overheat_limit = 8'sd125;
            default: c.overheat_limit = 8'($urandom_range(0, 255));
        endcase
        c.fan_grace         = grace_pick();
        c.sensor_grace      = grace_pick();
        c.fan_speed_percent = 7'($urandom_range(0, 127));
        return c;
    endfunction

    task automatic send_tick(dfhsm_pkg::t_item it);
        // While the safe settings are loaded, cut non-positive runs short of the sensor limit.
        if (safe_mode) begin
            if ($signed(it.temperature) <= 8'sd0) begin
                if (neg_run >= cur_cfg.sensor_grace) begin
                    it.temperature = 8'($urandom_range(1, 127));
                    neg_run = 0;
                end else begin
                    neg_run++;
                end
            end else begin
                neg_run = 0;
            end
        end
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        tick_if.valid          <= 1'b1;
        tick_if.tach_pulses    <= it.tach_pulses;
        tick_if.elapsed_ms     <= it.elapsed_ms;
        tick_if.temperature    <= it.temperature;
        tick_if.heater_request <= it.heater_request;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
    endtask

    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (monitor_status_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(logic [dfhsm_pkg::CFG_IDX_W-1:0] idx,
                           logic [dfhsm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Upper data bits of the narrower registers are random to show that each keeps only its width.
    task automatic load_cfg(dfhsm_pkg::t_cfg c);
        wait_idle();
        cur_cfg = c;
        put_reg(dfhsm_pkg::CFG_FAN_MIN_RPM, c.fan_min_rpm);
        put_reg(dfhsm_pkg::CFG_OVERHEAT_LIMIT, {8'($urandom), c.overheat_limit});
        put_reg(dfhsm_pkg::CFG_FAN_GRACE, {10'($urandom), c.fan_grace});
        put_reg(dfhsm_pkg::CFG_SENSOR_GRACE, {10'($urandom), c.sensor_grace});
        put_reg(dfhsm_pkg::CFG_FAN_SPEED_PERCENT, {9'($urandom), c.fan_speed_percent});
        put_reg(dfhsm_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_LAST + 1,
                                                      (1 << dfhsm_pkg::CFG_IDX_W) - 1)),
                dfhsm_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(int n, bit with_burst);
        int sent;
        int k;
        int kind;
        sent = 0;
        if (with_burst) begin
            // Close any open window, then pile up pulses until the accumulator saturates.
            send_tick(mk_tick(0, 1023, rand_temp(), $urandom_range(0, 255)));
            repeat (262) begin
                send_tick(mk_tick(255, $urandom_range(0, 3), rand_temp(),
                                  $urandom_range(0, 255)));
            end
            send_tick(mk_tick(255, 1023, rand_temp(), $urandom_range(0, 255)));
            sent = 264;
        end
        while (sent < n) begin
            src_idle_en = idle_on && ($urandom_range(0, 3) != 0);
            snk_idle_en = idle_on && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // A window of k ticks that adds up to roughly one window length.
                k = $urandom_range(2, 8);
                repeat (k) begin
                    send_tick(mk_tick($urandom_range(0, 255),
                                      $urandom_range(900 / k, 1100 / k),
                                      rand_temp(), $urandom_range(0, 255)));
                end
                sent += k;
            end else if (kind == 7) begin
                send_tick(mk_tick($urandom_range(0, 255), $urandom_range(0, 1023),
                                  $urandom_range(0, 255), $urandom_range(0, 255)));
                sent++;
            end else begin
                send_tick(mk_tick($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 1023,
                                  rand_temp(), $urandom_range(0, 1) * 255));
                sent++;
            end
        end
    endtask

    task automatic test_compare_paths();
        dfhsm_pkg::t_cfg c;
        int              pct_list[8];
        pct_list = '{0, 19, 20, 21, 99, 100, 101, 127};
        safe_mode = 1'b1;
        c.fan_min_rpm       = 16'd0;
        c.overheat_limit    = 8'sd127;
        c.fan_grace         = 6'd63;
        c.sensor_grace      = 6'd63;
        c.fan_speed_percent = 7'd40;
        load_cfg(c);
        send_tick(mk_tick(0, 0, 25, 0));
        send_tick(mk_tick(10, 100, 25, 1));
        send_tick(mk_tick(255, 899, 1, 99));
        // The window closes exactly at its length.
        send_tick(mk_tick(0, 1, 1, 100));
        // Overshoot: the excess milliseconds are dropped.
        send_tick(mk_tick(7, 1023, 125, 101));
        send_tick(mk_tick(0, 0, 127, 255));
        send_tick(mk_tick(1, 5, -128, 50));
        send_tick(mk_tick(1, 5, -40, 50));
        send_tick(mk_tick(1, 5, 0, 50));
        send_tick(mk_tick(1, 5, 1, 50));
        foreach (pct_list[i]) begin
            c.fan_speed_percent = 7'(pct_list[i]);
            load_cfg(c);
            send_tick(mk_tick($urandom_range(0, 255), $urandom_range(0, 200), 30,
                              $urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_safe();
        safe_mode = 1'b1;
        load_cfg(safe_cfg());
        send_random(300, 1'b1);
        repeat (3) begin
            load_cfg(safe_cfg());
            send_random(80, 1'b0);
        end
    endtask

    task automatic test_fault_latch();
        dfhsm_pkg::t_cfg c;
        safe_mode = 1'b0;
        c.fan_min_rpm       = 16'hFFFF;
        c.overheat_limit    = 8'sd40;
        c.fan_grace         = 6'd0;
        c.sensor_grace      = 6'd0;
        c.fan_speed_percent = 7'd40;
        load_cfg(c);
        // With zero grace each check trips on its first qualifying tick, later ones overwrite.
        send_tick(mk_tick(30, 10, 25, 50));
        send_tick(mk_tick(0, 10, 41, 50));
        send_tick(mk_tick(0, 10, 0, 50));
        send_tick(mk_tick(0, 10, -40, 0));
        c.fan_min_rpm    = 16'd0;
        c.overheat_limit = 8'sd125;
        c.fan_grace      = 6'd63;
        c.sensor_grace   = 6'd63;
        load_cfg(c);
        send_tick(mk_tick(0, 10, 126, 100));
        send_tick(mk_tick(0, 10, 127, 255));
        send_tick(mk_tick(0, 10, 125, 0));
        c.fan_min_rpm = 16'hFFFF;
        c.fan_grace   = 6'd2;
        load_cfg(c);
        repeat (5) send_tick(mk_tick(0, 10, 20, 60));
    endtask

    task automatic test_random_faults();
        safe_mode = 1'b0;
        repeat (5) begin
            load_cfg(fault_cfg());
            send_random(100, 1'b0);
        end
    endtask

    // The sink holds off long enough for the block to fill and drop its input ready.
    task automatic test_backpressure();
        load_cfg(fault_cfg());
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        hold_off_cycles = 80;
        repeat (30) begin
            send_tick(mk_tick($urandom_range(0, 255), $urandom_range(0, 1023),
                              rand_temp(), $urandom_range(0, 255)));
        end
    endtask

    task automatic test_back_to_back();
        idle_on     = 1'b0;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        load_cfg(fault_cfg());
        send_random(120, 1'b0);
    endtask

    initial begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= '0;
        cfg_wdata              <= '0;
        tick_if.valid          <= 1'b0;
        tick_if.tach_pulses    <= '0;
        tick_if.elapsed_ms     <= '0;
        tick_if.temperature    <= '0;
        tick_if.heater_request <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_compare_paths();
        test_random_safe();
        test_fault_latch();
        test_random_faults();
        test_backpressure();
        test_back_to_back();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && monitor_status_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
